// ===== sv/crc8cmf_pkg.sv =====
// Shared constants and the CRC-8 byte update for the measurement frame checker.
// No dependencies; imported by crc8_checked_measurement_frame_core.
`default_nettype none

package crc8cmf_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    typedef logic [7:0] byte_t;

    // MSB-first CRC-8 over one byte, unrolled into eight shift/xor steps.
    function automatic byte_t crc8_byte(input byte_t crc, input byte_t data);
        byte_t v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if ((v & CRC_TOP) != 8'h00)
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/crc8_checked_measurement_frame_core.sv =====
// Measurement frame checker: byte stream in, CRC-checked 32-bit measurement out.
// Depends on crc8cmf_pkg (CRC constants and byte update function).
//
// Channel  | Dir | tdata (low bit up)          | tuser        | tlast
// ---------+-----+-----------------------------+--------------+------
// s_axis   | in  | rx_byte[7:0]                | frame_start  | -
// m_axis   | out | measurement[31:0]           | crc_ok       | -
//
// Cycles: one input word per cycle while no held result stalls the input register;
// an accepted word passes through the input register, then the result register.
// Only the last CRC byte of a frame produces a result word; all others are absorbed.
// Reset: position cleared, running CRC at 0xFF, no word held in either register.
// Stalls: a held result blocks the input register only when the next item
// would produce a result too; all other items keep flowing.
`default_nettype none

module crc8_checked_measurement_frame_core #(
    parameter int WORD_BYTES = 2
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire         s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] measurement
    output logic        m_axis_tuser    // [0] crc_ok
);
    import crc8cmf_pkg::*;

    localparam int WORD_LEN  = WORD_BYTES + 1;
    localparam int FRAME_LEN = 2 * WORD_LEN;
    localparam int POS_W     = $clog2(FRAME_LEN);

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;

    // Frame state
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [7:0]       crc_reg,  crc_next;
    logic [31:0]      data_reg, data_next;
    logic             fwg_reg,  fwg_next;

    // Result register
    logic        out_valid_reg;
    logic [31:0] out_meas_reg;
    logic        out_ok_reg;

    // Effective state for the item in the input register
    logic [POS_W-1:0] pos_eff;
    logic [7:0]       crc_eff;
    logic [31:0]      data_eff;
    logic             fwg_eff;
    logic             second;
    logic             data_byte;
    logic             match;
    logic             result_hit;
    logic             advance;
    logic             ok;

    always_comb
    begin
        // A frame start discards any partial frame.
        pos_eff  = in_start_reg ? '0 : pos_reg;
        crc_eff  = in_start_reg ? CRC_INIT : crc_reg;
        data_eff = in_start_reg ? 32'd0 : data_reg;
        fwg_eff  = in_start_reg ? 1'b0 : fwg_reg;

        second    = pos_eff >= POS_W'(WORD_LEN);
        data_byte = second ? (pos_eff < POS_W'(WORD_LEN + WORD_BYTES))
                           : (pos_eff < POS_W'(WORD_BYTES));
        match     = in_byte_reg == crc_eff;
        ok        = fwg_eff && match;

        result_hit = in_valid_reg && !data_byte && second;
        advance    = in_valid_reg && (!result_hit || !out_valid_reg || m_axis_tready);

        pos_next  = pos_eff;
        crc_next  = crc_eff;
        data_next = data_eff;
        fwg_next  = fwg_eff;

        if (data_byte)
        begin
            crc_next  = crc8_byte(crc_eff, in_byte_reg);
            data_next = {data_eff[23:0], in_byte_reg};
            pos_next  = pos_eff + POS_W'(1);
        end
        else if (!second)
        begin
            crc_next = CRC_INIT;
            fwg_next = match;
            pos_next = pos_eff + POS_W'(1);
        end
        else
        begin
            // Frame complete: clear for the next frame.
            pos_next  = '0;
            crc_next  = CRC_INIT;
            data_next = 32'd0;
            fwg_next  = 1'b0;
        end
    end

    assign s_axis_tready = !in_valid_reg || advance;

    // Input register: load on accept, drop once processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // Frame state: advance when the held item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            crc_reg  <= CRC_INIT;
            data_reg <= 32'd0;
            fwg_reg  <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            data_reg <= data_next;
            fwg_reg  <= fwg_next;
        end
    end

    // Result register: hold until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && result_hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result_hit)
        begin
            out_meas_reg <= ok ? data_eff : 32'd0;
            out_ok_reg   <= ok;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_meas_reg;
    assign m_axis_tuser  = out_ok_reg;

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(FRAME_LEN - 1) || pos_reg == POS_W'(FRAME_LEN - 1))
        else $error("frame position out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ok_reg |-> out_meas_reg == 32'd0)
        else $error("failed frame carries nonzero measurement");

    a_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_hit |-> pos_eff == POS_W'(FRAME_LEN - 1))
        else $error("result produced before last frame byte");

    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_hit |=> pos_reg == '0 && crc_reg == CRC_INIT)
        else $error("frame state not cleared after result");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_meas_reg))
        else $error("held result overwritten");
`endif

endmodule

`default_nettype wire
